### sv/chte_pkg.sv
package chte_pkg;

	localparam int BUCKETS = 10;
	localparam int WAYS    = 4;
	localparam int SLOTS   = BUCKETS * WAYS;

	localparam int KEY_W   = 31;
	localparam int VAL_W   = 32;
	localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);

	// reciprocal of the bucket count: floor(key * REC_MUL / 2**REC_SH) is exact
	// for every KEY_W-bit key
	localparam int REC_SH  = KEY_W + $clog2(BUCKETS);
	localparam int REC_W   = KEY_W + 1;
	localparam int QUOT_W  = KEY_W + REC_W - REC_SH;
	localparam longint unsigned REC_MUL_FULL =
		((64'd1 << REC_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [REC_W-1:0] REC_MUL = REC_W'(REC_MUL_FULL);

	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 8;

	typedef logic [BKT_W-1:0] bucket_t;
	typedef logic [WAY_W-1:0] way_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	typedef slot_t [WAYS-1:0] bucket_word_t;

	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_REMOVE = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_REPLACED  = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_READ,
		S_CMP
	} state_t;

	// bucket memory request, one per cycle
	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		bucket_t          addr;
		logic [WAYS-1:0]  wr_valid;
		bucket_word_t     wr_word;
	} mem_req_t;

endpackage

### sv/chte_mod_unit.sv
module chte_mod_unit
	import chte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output bucket_t          rem
);

	logic [KEY_W-1:0]       key_q;
	logic [KEY_W+REC_W-1:0] prod_q;
	bucket_t                rem_q;
	logic                   mul_q;
	logic                   sub_q;
	logic                   done_q;
	logic [QUOT_W-1:0]      quot;
	logic [KEY_W-1:0]       quot_x_b;
	logic [KEY_W-1:0]       diff;

	// quotient from the reciprocal product, then multiply back and subtract
	assign quot     = prod_q[KEY_W+REC_W-1:REC_SH];
	assign quot_x_b = KEY_W'(quot) * KEY_W'(BUCKETS);
	assign diff     = key_q - quot_x_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			sub_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= start;
			sub_q  <= mul_q;
			done_q <= sub_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
		if (mul_q) begin
			prod_q <= (KEY_W+REC_W)'(key_q) * (KEY_W+REC_W)'(REC_MUL);
		end
		if (sub_q) begin
			rem_q <= diff[BKT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### sv/chte_bucket_mem.sv
module chte_bucket_mem
	import chte_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  mem_req_t        req,
	output logic [WAYS-1:0] rd_valid,
	output bucket_word_t    rd_word
);

	logic [WAYS-1:0] valid_q [BUCKETS];
	bucket_word_t    ram [BUCKETS];
	logic [WAYS-1:0] rd_valid_q;
	bucket_word_t    rd_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
		end else if (req.wr_en) begin
			valid_q[req.addr] <= req.wr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ram[req.addr] <= req.wr_word;
		end
		if (req.rd_en) begin
			rd_word_q  <= ram[req.addr];
			rd_valid_q <= valid_q[req.addr];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_word  = rd_word_q;

endmodule

### sv/chained_hash_table_engine_unit.sv
// channel | dir | tdata (low bit up)                      | tuser
// s_*     | in  | key[30:0], value_handle[62:31], 0[63]   | func[0]
// m_*     | out | status[2:0], table_empty[3], 0[7:4]     | -
//
// An item goes from its input beat to its result being offered through the
// remainder unit that picks the bucket (reciprocal multiply, then multiply
// back and subtract), the hand-over of the bucket to the sequencer, the
// bucket memory read, and compare and write-back.
// The block takes one item at a time; s_tready is high only when idle, so a
// new input beat is taken only once the last item has left compare.
// A result waits in the output register; the next item may be accepted then,
// and it holds in compare until the waiting beat is taken.
// arst_n clears all slot valid bits and the entry count at once.
module chained_hash_table_engine_unit
	import chte_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // key[30:0], value_handle[62:31], zero[63]
	input  logic [0:0]          s_tuser,   // func[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // status[2:0], table_empty[3], zero[7:4]
);

	state_t            state_q, state_next;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	func_t             func_q;
	logic [CNT_W-1:0]  count_q, count_next;
	logic              m_tvalid_q;
	status_t           status_q, status_next;
	logic              empty_q;

	logic              accept;
	logic              mod_done;
	bucket_t           bucket;
	logic [WAYS-1:0]   rd_valid;
	bucket_word_t      rd_word;
	mem_req_t          req;

	logic              hit_any, free_any;
	way_t              hit_way, free_way;
	logic              finish;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	chte_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (s_tdata[KEY_W-1:0]),
		.done   (mod_done),
		.rem    (bucket)
	);

	chte_bucket_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_valid (rd_valid),
		.rd_word  (rd_word)
	);

	// way match and lowest free way; keys are unique per bucket
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_valid[w] && (rd_word[w].key == key_q)) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!rd_valid[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// sequencer: next state, memory request, result
	always_comb begin
		state_next   = state_q;
		count_next   = count_q;
		status_next  = status_q;
		finish       = 1'b0;
		req.rd_en    = 1'b0;
		req.wr_en    = 1'b0;
		req.addr     = bucket;
		req.wr_valid = rd_valid;
		req.wr_word  = rd_word;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_next = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_next = S_READ;
				end
			end
			S_READ: begin
				req.rd_en  = 1'b1;
				state_next = S_CMP;
			end
			S_CMP: begin
				// hold here while the previous result still waits
				if (!m_tvalid_q || m_tready) begin
					finish     = 1'b1;
					state_next = S_IDLE;
					if (func_q == FN_INSERT) begin
						if (hit_any) begin
							req.wr_en                  = 1'b1;
							req.wr_word[hit_way].value = val_q;
							status_next                = STAT_REPLACED;
						end else if (free_any) begin
							req.wr_en                  = 1'b1;
							req.wr_valid[free_way]     = 1'b1;
							req.wr_word[free_way].key  = key_q;
							req.wr_word[free_way].value = val_q;
							count_next                 = count_q + 1'b1;
							status_next                = STAT_INSERTED;
						end else begin
							status_next = STAT_FULL;
						end
					end else begin
						if (hit_any) begin
							req.wr_en             = 1'b1;
							req.wr_valid[hit_way] = 1'b0;
							count_next            = count_q - 1'b1;
							status_next           = STAT_REMOVED;
						end else begin
							status_next = STAT_NOT_FOUND;
						end
					end
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			count_q <= count_next;
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// capture the item, and load the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= s_tdata[KEY_W-1:0];
			val_q  <= s_tdata[KEY_W+VAL_W-1:KEY_W];
			func_q <= func_t'(s_tuser[0]);
		end
		if (finish) begin
			status_q <= status_next;
			empty_q  <= (count_next == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, empty_q, status_q};

endmodule

### sv/chte_checker.sv
module chte_checker
	import chte_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// one item at a time: ready drops after an input beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// the result never shows up the cycle after the input beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] == STAT_INSERTED || m_tdata[2:0] == STAT_REPLACED ||
			m_tdata[2:0] == STAT_REMOVED || m_tdata[2:0] == STAT_NOT_FOUND ||
			m_tdata[2:0] == STAT_FULL) && (m_tdata[7:4] == 4'b0000))
		else $error("bad result code or padding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

endmodule

bind chained_hash_table_engine_unit chte_checker u_chte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
